/* rtl/nsr_pkg.sv */
// Shared constants and types for the Newton-Raphson square root block.
package nsr_pkg;

  localparam int FRAC_BITS_DEFAULT = 16;

  localparam int VALUE_W = 32;
  localparam int GUESS_W = 32;
  localparam int PROD_W  = 2 * GUESS_W;
  localparam int ROOT_W  = 24;
  localparam int TOL_W   = 16;
  localparam int ITER_W  = 6;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_TOLERANCE      = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_ITERATIONS = 1'b1;

  localparam logic [TOL_W-1:0]  TOLERANCE_RESET      = 16'd1;
  localparam logic [ITER_W-1:0] MAX_ITERATIONS_RESET = 6'd32;

  localparam logic [ROOT_W-1:0] ROOT_MAX = {ROOT_W{1'b1}};

  // Status of the divider as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } nsr_div_stat_t;

endpackage

/* rtl/nsr_if.sv */
// Handshake interfaces for the operand and result channels.
interface nsr_in_if
  import nsr_pkg::*;
  ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface nsr_out_if
  import nsr_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [ROOT_W-1:0] root;
  logic              negative_error;
  logic              not_converged;
  logic [ITER_W-1:0] steps_taken;

  modport source (output valid, output root, output negative_error,
                  output not_converged, output steps_taken, input ready);
  modport sink   (input valid, input root, input negative_error,
                  input not_converged, input steps_taken, output ready);
endinterface

/* rtl/nsr_div.sv */
// Restoring shift-subtract divider, one quotient bit per cycle.
module nsr_div
  import nsr_pkg::*;
#(
  parameter int DIVIDEND_W = 47,
  parameter int DIVISOR_W  = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic [DIVIDEND_W-1:0] quotient,
  output nsr_div_stat_t         stat
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dvs;
  logic [CNT_W-1:0]      count;
  logic                  busy;
  logic                  done;

  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    trial_diff;
  logic                  fits;

  assign trial      = {rem, quo[DIVIDEND_W-1]};
  assign trial_diff = trial - {1'b0, dvs};
  assign fits       = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(DIVIDEND_W);
      end else if (busy) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Dividend bits shift out at the top while quotient bits shift in at the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[DIVIDEND_W-2:0], fits};
      rem <= fits ? trial_diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end
  end

  assign quotient  = quo;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

/* rtl/newton_square_root.sv */
// Top level of the Newton-Raphson fixed-point square root block.
//
//   channel   dir  handshake            payload
//   operand   in   valid / ready        value (signed, FRAC_BITS fraction bits)
//   result    out  valid / ready        root, negative_error, not_converged,
//                                       steps_taken
//   cfg       in   cfg_we (no wait)     cfg_index, cfg_data
//
// One item is worked at a time; operand.ready is high only while the sequencer
// is idle. Most of each Newton step is spent in the bit-serial divider, which
// produces one quotient bit per cycle of the (31 + FRAC_BITS)-bit dividend
// (47 bits at Q16.16). On top of the steps come the first square, the final
// residual test and the output write. A negative operand goes from idle
// straight to the done state and skips the iteration.
// Reset is synchronous and active high; it returns the registers to their
// reset values and drops any item in flight. The result sits in an output
// register, so a stalled result only holds back the next item's final write.

module newton_square_root
  import nsr_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  nsr_in_if.sink                 operand,
  nsr_out_if.source              result,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // Operand is non-negative once it gets to the iteration, so 31 bits suffice.
  localparam int RAW_W      = VALUE_W - 1;
  localparam int DIVIDEND_W = RAW_W + FRAC_BITS;
  localparam int SQ_W       = PROD_W - FRAC_BITS;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SQUARE = 6'b000010,
    S_CHECK  = 6'b000100,
    S_DIVIDE = 6'b001000,
    S_UPDATE = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [TOL_W-1:0]  tolerance;
  logic [ITER_W-1:0] max_iterations;

  // Working registers for the item in flight.
  logic [RAW_W-1:0]   raw;
  logic [GUESS_W-1:0] guess;
  logic [PROD_W-1:0]  prod;
  logic [ITER_W-1:0]  steps;
  logic               neg_flag;
  logic               conv_flag;

  // Output register.
  logic              out_valid;
  logic [ROOT_W-1:0] out_root;
  logic              out_neg;
  logic              out_nconv;
  logic [ITER_W-1:0] out_steps;

  // Divider hookup.
  logic                  div_start;
  logic [DIVIDEND_W-1:0] div_dividend;
  logic [DIVIDEND_W-1:0] div_quotient;
  nsr_div_stat_t         div_stat;

  // Residual test on the registered square.
  logic [SQ_W-1:0] sq;
  logic [SQ_W-1:0] raw_ext;
  logic [SQ_W-1:0] residual;
  logic            converged;
  logic            cap_hit;

  // Guess update.
  logic [DIVIDEND_W:0]   upd_sum;
  logic [DIVIDEND_W-1:0] upd_half;
  logic [GUESS_W-1:0]    guess_next;

  logic in_fire;
  logic out_free;

  assign in_fire  = operand.valid && operand.ready;
  assign out_free = !out_valid || result.ready;

  assign operand.ready = (state == S_IDLE);

  // The square is truncated to FRAC_BITS fraction bits, as is the operand.
  assign sq        = prod[PROD_W-1:FRAC_BITS];
  assign raw_ext   = SQ_W'(raw);
  assign residual  = (sq >= raw_ext) ? (sq - raw_ext) : (raw_ext - sq);
  assign converged = residual < SQ_W'(tolerance);
  assign cap_hit   = steps >= max_iterations;

  assign div_dividend = {raw, {FRAC_BITS{1'b0}}};
  assign div_start    = (state == S_CHECK) && !converged && !cap_hit;

  // New guess is the mean of quotient and old guess, held inside
  // [1, 2**GUESS_W - 1] so the next division never sees a zero divisor.
  assign upd_sum  = {1'b0, div_quotient} + (DIVIDEND_W+1)'(guess);
  assign upd_half = upd_sum[DIVIDEND_W:1];

  always_comb begin
    if (upd_half[DIVIDEND_W-1:GUESS_W] != '0) begin
      guess_next = {GUESS_W{1'b1}};
    end else if (upd_half == '0) begin
      guess_next = GUESS_W'(1);
    end else begin
      guess_next = upd_half[GUESS_W-1:0];
    end
  end

  nsr_div #(
    .DIVIDEND_W (DIVIDEND_W),
    .DIVISOR_W  (GUESS_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (guess),
    .quotient (div_quotient),
    .stat     (div_stat)
  );

  // Configuration writes must arrive only while the block is idle; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance      <= TOLERANCE_RESET;
      max_iterations <= MAX_ITERATIONS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TOLERANCE:      tolerance      <= cfg_data[TOL_W-1:0];
        REG_MAX_ITERATIONS: max_iterations <= cfg_data[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: square, test, divide, update, repeat to convergence or cap; negatives skip to done.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            state <= operand.value[VALUE_W-1] ? S_DONE : S_SQUARE;
          end
        end
        S_SQUARE: state <= S_CHECK;
        S_CHECK: begin
          state <= (converged || cap_hit) ? S_DONE : S_DIVIDE;
        end
        S_DIVIDE: begin
          if (div_stat.done) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: state <= S_SQUARE;
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers follow the sequencer; they need no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      raw       <= operand.value[RAW_W-1:0];
      neg_flag  <= operand.value[VALUE_W-1];
      guess     <= GUESS_W'(1) << FRAC_BITS;
      steps     <= '0;
      conv_flag <= 1'b0;
    end
    if (state == S_SQUARE) begin
      prod <= PROD_W'(guess) * PROD_W'(guess);
    end
    if (state == S_CHECK) begin
      conv_flag <= converged;
    end
    if (state == S_UPDATE) begin
      guess <= guess_next;
      steps <= steps + ITER_W'(1);
    end
  end

  // Output register; a result taken this cycle makes room for the next one.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      if (neg_flag) begin
        out_root  <= '0;
        out_nconv <= 1'b0;
        out_steps <= '0;
      end else begin
        out_root  <= (guess[GUESS_W-1:ROOT_W] != '0) ? ROOT_MAX : guess[ROOT_W-1:0];
        out_nconv <= !conv_flag;
        out_steps <= steps;
      end
      out_neg <= neg_flag;
    end
  end

  assign result.valid          = out_valid;
  assign result.root           = out_root;
  assign result.negative_error = out_neg;
  assign result.not_converged  = out_nconv;
  assign result.steps_taken    = out_steps;

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the Newton-Raphson fixed-point square root block.
module tb_top;
  import nsr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The block runs at its default Q16.16 format.
  localparam int FRAC = FRAC_BITS_DEFAULT;

  // The largest value that the working guess can hold.
  localparam logic [63:0] GUESS_LIMIT = 64'hFFFF_FFFF;

  // The slowest correct run has about 620 items. None makes more than
  // 63 updates, and on top come the receiver's stalls and the one long
  // hold-off. The limit below leaves a wide margin over that.
  localparam int unsigned CYCLE_LIMIT = 8_000_000;

  // The receiver holds off for this many cycles during the pressure phase.
  localparam int unsigned HOLD_CYCLES = 3000;

  // After the last result, the block gets this many cycles to settle before
  // a register write or the end of the run.
  localparam int unsigned SETTLE_CYCLES = 8;

  // One result item, as the block should produce it.
  typedef struct packed {
    logic [ROOT_W-1:0] root;
    logic              negative_error;
    logic              not_converged;
    logic [ITER_W-1:0] steps_taken;
  } root_result_t;

  logic clk = 1'b0;
  logic rst;

  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  nsr_in_if  operand_ch ();
  nsr_out_if result_ch ();

  newton_square_root #(
    .FRAC_BITS (FRAC)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .operand   (operand_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Operands waiting to be offered, and the results that accepted operands
  // must produce, oldest first.
  logic [VALUE_W-1:0] pending_operands[$];
  root_result_t       expected_roots[$];

  // The testbench's own copy of the two configuration registers.
  logic [TOL_W-1:0]  tol_reg  = TOLERANCE_RESET;
  logic [ITER_W-1:0] iter_cap = MAX_ITERATIONS_RESET;

  // High while an operand item sits on the channel and has not been taken.
  bit in_busy = 1'b0;

  // Percentages of cycles in which the sender and the receiver stay idle.
  int unsigned snd_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;

  // The long receiver hold-off is requested by the stimulus and counted down
  // in a process of its own.
  logic        hold_req = 1'b0;
  int unsigned hold_left = 0;

  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  // Computes the result for one operand under the current registers. A
  // negative operand is an error with a zero root. Otherwise the guess starts
  // at 1.0 and the residual test comes before each update, so a first guess
  // that already fits gives zero steps. The quotient, the square and the
  // halving all truncate. A guess that would fall to zero is held at one LSB,
  // and the root saturates to the width of the result.
  function automatic root_result_t predict_sqrt(input logic [VALUE_W-1:0] operand);
    logic [63:0]  raw;
    logic [63:0]  guess;
    logic [63:0]  square;
    logic [63:0]  resid;
    logic [63:0]  quotient;
    logic [63:0]  next_guess;
    int unsigned  steps;
    bit           met;
    bit           stop;
    root_result_t res;
    res = '0;
    if (operand[VALUE_W-1]) begin
      res.negative_error = 1'b1;
      return res;
    end
    raw   = {32'd0, operand};
    guess = 64'd1 << FRAC;
    steps = 0;
    met   = 1'b0;
    stop  = 1'b0;
    while (!stop) begin
      square = (guess * guess) >> FRAC;
      resid  = (square >= raw) ? square - raw : raw - square;
      if (resid < {48'd0, tol_reg}) begin
        met  = 1'b1;
        stop = 1'b1;
      end else if (steps >= iter_cap) begin
        stop = 1'b1;
      end else begin
        quotient   = (raw << FRAC) / guess;
        next_guess = (quotient + guess) >> 1;
        if (next_guess > GUESS_LIMIT) begin
          next_guess = GUESS_LIMIT;
        end
        if (next_guess == 64'd0) begin
          next_guess = 64'd1;
        end
        guess = next_guess;
        steps++;
      end
    end
    res.root          = (guess > {40'd0, ROOT_MAX}) ? ROOT_MAX : guess[ROOT_W-1:0];
    res.not_converged = !met;
    res.steps_taken   = ITER_W'(steps);
    return res;
  endfunction

  // Draws one random operand. Most are non-negative with a spread of sizes,
  // so that the iteration runs for varied numbers of steps. Some are exact
  // squares, which can converge, and some are negative or fully random.
  function automatic logic [VALUE_W-1:0] rand_operand();
    int unsigned k;
    case ($urandom_range(9))
      0: begin
        return {1'b1, 31'($urandom)};
      end
      1: begin
        k = $urandom_range(181);
        return VALUE_W'((k * k) << FRAC);
      end
      2: begin
        return VALUE_W'($urandom_range(16'hFFFF));
      end
      3: begin
        return VALUE_W'($urandom_range(15));
      end
      4: begin
        return VALUE_W'($urandom);
      end
      default: begin
        return VALUE_W'($urandom >> $urandom_range(31, 1));
      end
    endcase
  endfunction

  // Writes one configuration register and updates the local copy to match.
  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == REG_TOLERANCE) begin
      tol_reg = data[TOL_W-1:0];
    end else begin
      iter_cap = data[ITER_W-1:0];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input int unsigned tol, input int unsigned cap);
    cfg_write(REG_TOLERANCE, CFG_DATA_W'(tol));
    cfg_write(REG_MAX_ITERATIONS, CFG_DATA_W'(cap));
  endtask

  // Waits until every operand has been taken and every result has come back,
  // then gives the block a short pause before anything else happens.
  task automatic wait_drained();
    while (pending_operands.size() != 0 || in_busy || expected_roots.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic queue_random(input int unsigned count);
    repeat (count) pending_operands.push_back(rand_operand());
  endtask

  // Operand driver. A new item is put on the channel at the falling edge
  // once the previous one has been taken; valid stays high across
  // back-to-back items, so it gets at most one assignment per edge.
  always @(negedge clk) begin
    if (rst) begin
      operand_ch.valid <= 1'b0;
      operand_ch.value <= '0;
    end else if (!in_busy) begin
      if (pending_operands.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
        operand_ch.value <= pending_operands.pop_front();
        operand_ch.valid <= 1'b1;
        in_busy = 1'b1;
      end else begin
        operand_ch.valid <= 1'b0;
        operand_ch.value <= VALUE_W'($urandom);
      end
    end
  end

  // Operand monitor. Every accepted item gets its expected result computed
  // right away, under the registers in force at that moment.
  always @(posedge clk) begin
    if (!rst && operand_ch.valid && operand_ch.ready) begin
      expected_roots.push_back(predict_sqrt(operand_ch.value));
      in_busy = 1'b0;
    end
  end

  // Long hold-off counter for the receiver.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_req) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result receiver. It stalls at random, and throughout a hold-off.
  always @(negedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Result monitor. Each accepted result is checked field by field against
  // the oldest expectation.
  always @(posedge clk) begin
    root_result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_roots.size() == 0) begin
        $error("result item arrived with no expectation waiting");
        mismatch_count++;
      end else begin
        want = expected_roots.pop_front();
        if (result_ch.root !== want.root) begin
          $error("root: expected %0h, got %0h", want.root, result_ch.root);
          mismatch_count++;
        end
        if (result_ch.negative_error !== want.negative_error) begin
          $error("negative_error: expected %0d, got %0d",
                 want.negative_error, result_ch.negative_error);
          mismatch_count++;
        end
        if (result_ch.not_converged !== want.not_converged) begin
          $error("not_converged: expected %0d, got %0d",
                 want.not_converged, result_ch.not_converged);
          mismatch_count++;
        end
        if (result_ch.steps_taken !== want.steps_taken) begin
          $error("steps_taken: expected %0d, got %0d",
                 want.steps_taken, result_ch.steps_taken);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog. A hung block ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    // Every input is known from time zero.
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = REG_TOLERANCE;
    cfg_data         = '0;
    operand_ch.valid = 1'b0;
    operand_ch.value = '0;
    result_ch.ready  = 1'b0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The first stretch has a lazy sender and a very lazy receiver.
    snd_idle_pct = 29;
    rcv_idle_pct = 71;

    // Reset registers: tolerance of one LSB and a cap of 32 steps. The
    // directed operands cover 1.0, which fits at once, zero, the smallest
    // and largest positive values, the most negative value and minus one
    // LSB, a value just below 1.0, and a few ordinary ones.
    pending_operands.push_back(32'h0001_0000);
    pending_operands.push_back(32'h0000_0000);
    pending_operands.push_back(32'h0000_0001);
    pending_operands.push_back(32'h0000_FFFF);
    pending_operands.push_back(32'h0004_0000);
    pending_operands.push_back(32'h7FFF_FFFF);
    pending_operands.push_back(32'h8000_0000);
    pending_operands.push_back(32'hFFFF_FFFF);
    pending_operands.push_back(32'h0002_0000);
    pending_operands.push_back(32'h1234_5678);
    queue_random(100);
    wait_drained();

    // Zero tolerance can never be met, so every non-negative item runs to
    // the largest cap. With a zero operand the guess keeps halving until it
    // would reach zero and is held at one LSB instead.
    set_config(0, 63);
    pending_operands.push_back(32'h0000_0000);
    pending_operands.push_back(32'h7FFF_FFFF);
    pending_operands.push_back(32'h0001_0000);
    pending_operands.push_back(32'hC000_0000);
    queue_random(50);
    wait_drained();

    // Widest tolerance and a single step. After one step from 1.0 a large
    // operand leaves a guess far above the root's range, so the root
    // saturates.
    set_config(16'hFFFF, 1);
    pending_operands.push_back(32'h7FFF_FFFF);
    pending_operands.push_back(32'h4000_0000);
    pending_operands.push_back(32'h0000_0005);
    queue_random(80);
    wait_drained();

    // From here on the receiver is the quicker side.
    snd_idle_pct = 71;
    rcv_idle_pct = 29;

    // A cap of zero allows no update at all: only an operand that the first
    // guess already fits comes back as converged.
    set_config(1, 0);
    pending_operands.push_back(32'h0001_0000);
    pending_operands.push_back(32'h0002_0000);
    queue_random(20);
    wait_drained();

    // Random register settings. In the first of them the receiver holds off
    // for a long stretch while operands keep coming, so that the result
    // register fills and the block stops taking new operands.
    for (int phase = 0; phase < 4; phase++) begin
      set_config($urandom_range(3) != 0 ? $urandom_range(1024, 1) : $urandom_range(16'hFFFF),
                 $urandom_range(24, 1));
      if (phase == 0) begin
        @(negedge clk);
        hold_req <= 1'b1;
        @(negedge clk);
        hold_req <= 1'b0;
      end
      queue_random(50);
      wait_drained();
    end

    // The last stretch runs with no idling on either side.
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    set_config(128, 40);
    queue_random(150);
    wait_drained();

    if (mismatch_count == 0 && expected_roots.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* newton_square_root.f */
rtl/nsr_pkg.sv
rtl/nsr_if.sv
rtl/nsr_div.sv
rtl/newton_square_root.sv
verif/tb_top.sv
